>>> hw/rtl/fcsl_pkg.sv
// shared types and constants for the fixed capacity sequential list
package fcsl_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned POS_W = 7;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned CAP_W = 7;

  typedef enum logic [2:0] {
    FN_APPEND       = 3'd0,
    FN_PREPEND      = 3'd1,
    FN_INSERT_AT    = 3'd2,
    FN_REMOVE_LAST  = 3'd3,
    FN_REMOVE_FIRST = 3'd4,
    FN_REMOVE_AT    = 3'd5,
    FN_SEARCH       = 3'd6
  } func_t;

  typedef struct packed {
    logic                    en;
    logic                    shift_up;
    logic                    shift_down;
    logic [POS_W-1:0]        k;
    logic [CNT_W-1:0]        cnt;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

>>> hw/rtl/fcsl_cell.sv
// one list slot: holds an entry, shifts with its neighbors, compares for search
module fcsl_cell
  import fcsl_pkg::*;
#(
  parameter int unsigned IW  = 7,
  parameter int unsigned IDX = 0
) (
  input  logic                    clk,
  input  cell_cmd_t               cmd,
  input  logic signed [VAL_W-1:0] left_i,
  input  logic signed [VAL_W-1:0] right_i,
  output logic signed [VAL_W-1:0] data_o,
  output logic                    hit_o
);

  localparam logic [IW-1:0] MY = IW'(IDX);

  logic signed [VAL_W-1:0] data_r, data_nxt;
  logic                    hit_r, hit_nxt;
  logic [IW-1:0]           k_w, cnt_w;

  assign k_w   = IW'(cmd.k);
  assign cnt_w = IW'(cmd.cnt);

  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_up) begin
      if (MY > k_w) begin
        data_nxt = left_i;
      end else if (MY == k_w) begin
        data_nxt = cmd.value;
      end
    end else if (cmd.shift_down) begin
      if (MY >= k_w) begin
        data_nxt = right_i;
      end
    end
  end

  // match against the entry as it was before this item
  assign hit_nxt = (data_r == cmd.value) && (MY < cnt_w);

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      data_r <= data_nxt;
      hit_r  <= hit_nxt;
    end
  end

  assign data_o = data_r;
  assign hit_o  = hit_r;

endmodule

>>> hw/rtl/fixed_capacity_sequential_list.sv
// top level of the fixed capacity sequential list
// One item is taken per cycle while in_stall is low; its result is held in s1,
// then in the output register. Each entry lives in its own cell of a row of
// DEPTH cells; an insert, or a remove other than remove-last, moves every cell
// past the target slot to its neighbor in the same cycle, and a search compares
// all cells at once, registers the per-cell match and ORs the matches as the
// item enters the output register. The output register lets a new item in
// while a result waits to be taken. Write the capacity only while idle.
module fixed_capacity_sequential_list
  import fcsl_pkg::*;
#(
  parameter int unsigned DEPTH = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              in_func,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_ok,
  output logic [CNT_W-1:0]        out_entry_count,
  output logic                    out_is_full,
  output logic                    out_is_empty,
  input  logic                    cfg_we,
  input  logic [CAP_W-1:0]        cfg_wdata
);

  localparam int unsigned CIW = $clog2(DEPTH);
  localparam int unsigned IW  = (CIW > POS_W) ? CIW : POS_W;
  localparam int unsigned CAP_MAX = (1 << CAP_W) - 1;
  localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'((DEPTH > CAP_MAX) ? CAP_MAX : DEPTH);

  logic [CAP_W-1:0] cap_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             s1_valid_r, s1_ok_r, s1_srch_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic             out_valid_r, out_ok_r, out_full_r, out_empty_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic [CAP_W-1:0] eff_cap;
  logic             full, acc, out_busy, s1_move;
  logic             ins_pos_ok, rem_pos_ok, op_ok;
  logic             full_after;
  func_t            fn;
  cell_cmd_t        cmd;

  logic signed [VAL_W-1:0] cell_q [DEPTH];
  logic [DEPTH-1:0]        hits;

  assign fn       = func_t'(in_func);
  assign eff_cap  = (cap_r > DEPTH_CAP) ? DEPTH_CAP : cap_r;
  assign full     = (count_r >= eff_cap);
  assign out_busy = out_valid_r && out_stall;
  assign in_stall = s1_valid_r && out_busy;
  assign acc      = in_valid && !in_stall;
  assign s1_move  = s1_valid_r && !out_busy;

  assign ins_pos_ok = (in_position != '0) &&
                      ({1'b0, in_position} <= ({1'b0, count_r} + 8'd1));
  assign rem_pos_ok = (in_position != '0) && (in_position <= count_r);

  // decode one item into a row command
  always_comb begin
    cmd            = '0;
    cmd.en         = acc;
    cmd.cnt        = count_r;
    cmd.value      = in_value;
    op_ok          = 1'b0;
    count_nxt      = count_r;
    case (fn)
      FN_APPEND: begin
        op_ok = !full;
        cmd.k = count_r;
        cmd.shift_up = acc && op_ok;
      end
      FN_PREPEND: begin
        op_ok = !full;
        cmd.k = '0;
        cmd.shift_up = acc && op_ok;
      end
      FN_INSERT_AT: begin
        op_ok = !full && ins_pos_ok;
        cmd.k = in_position - POS_W'(1);
        cmd.shift_up = acc && op_ok;
      end
      FN_REMOVE_LAST: begin
        op_ok = (count_r != '0);
      end
      FN_REMOVE_FIRST: begin
        op_ok = (count_r != '0);
        cmd.k = '0;
        cmd.shift_down = acc && op_ok;
      end
      FN_REMOVE_AT: begin
        op_ok = (count_r != '0) && rem_pos_ok;
        cmd.k = in_position - POS_W'(1);
        cmd.shift_down = acc && op_ok;
      end
      FN_SEARCH: begin
        op_ok = 1'b0;
      end
      default: begin
        op_ok = 1'b0;
      end
    endcase
    if (op_ok) begin
      if (fn == FN_APPEND || fn == FN_PREPEND || fn == FN_INSERT_AT) begin
        count_nxt = count_r + CNT_W'(1);
      end else begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid_l
      assign left_d = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_mid_r
      assign right_d = cell_q[i+1];
    end
    fcsl_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .left_i  (left_d),
      .right_i (right_d),
      .data_o  (cell_q[i]),
      .hit_o   (hits[i])
    );
  end

  assign full_after = (s1_cnt_r >= eff_cap);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_W'(64);
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (acc) begin
        count_r   <= count_nxt;
        s1_ok_r   <= op_ok;
        s1_srch_r <= (fn == FN_SEARCH);
        s1_cnt_r  <= count_nxt;
      end
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        out_ok_r    <= s1_srch_r ? (|hits) : s1_ok_r;
        out_cnt_r   <= s1_cnt_r;
        out_full_r  <= full_after;
        out_empty_r <= (s1_cnt_r == '0);
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_entry_count = out_cnt_r;
  assign out_is_full     = out_full_r;
  assign out_is_empty    = out_empty_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CAP)
    else $error("entry count beyond storage");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1)) ||
            (count_r == $past(count_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_s1_drain: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_valid)
    else $error("result lost between stages");
`endif

endmodule

>>> verif/tb.sv
// self-checking testbench for the fixed capacity sequential list
`timescale 1ns / 1ps

module tb;
  import fcsl_pkg::*;

  localparam int unsigned LIST_DEPTH = 64;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned N_ROWS = 28;
  localparam int unsigned N_PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 94;
  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam logic ROW_OP = 1'b0;
  localparam logic ROW_CFG = 1'b1;
  localparam logic CHK_MODEL = 1'b0;
  localparam logic CHK_TYPED = 1'b1;
  localparam int MODE_FILL = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX = 2;

  typedef struct packed {
    logic             ok;
    logic [CNT_W-1:0] cnt;
    logic             full;
    logic             empty;
  } list_status_t;

  typedef struct packed {
    logic                    kind;
    logic [2:0]              f;
    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0]        p;
    logic                    typed;
    list_status_t            want;
  } script_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [2:0]              in_func = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic [POS_W-1:0]        in_position = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_ok;
  logic [CNT_W-1:0]        out_entry_count;
  logic                    out_is_full;
  logic                    out_is_empty;
  logic                    cfg_we = 1'b0;
  logic [CAP_W-1:0]        cfg_wdata = '0;

  logic                    row_typed = 1'b0;
  list_status_t            row_want = '0;

  logic signed [VAL_W-1:0] list_mem [LIST_DEPTH];
  int unsigned             list_cnt = 0;
  int unsigned             cap_now = 64;
  list_status_t            pending_status [$];
  list_status_t            seen_status;
  list_status_t            owed_status;
  int unsigned             bad_status_cnt = 0;
  int unsigned             quiet_cycles = 0;
  bit                      idle_on = 1'b1;
  int unsigned             stall_left = 0;
  script_row_t             script [N_ROWS];

  fixed_capacity_sequential_list #(.DEPTH(LIST_DEPTH)) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_value        (in_value),
    .in_position     (in_position),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_entry_count (out_entry_count),
    .out_is_full     (out_is_full),
    .out_is_empty    (out_is_empty),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic list_status_t st(input logic ok, input int unsigned cnt,
                                      input logic full, input logic empty);
    list_status_t s;
    s.ok = ok;
    s.cnt = cnt[CNT_W-1:0];
    s.full = full;
    s.empty = empty;
    return s;
  endfunction

  function automatic void store_at(input int unsigned idx, input logic signed [VAL_W-1:0] v);
    for (int unsigned i = list_cnt; i > idx; i--) begin
      list_mem[i] = list_mem[i-1];
    end
    list_mem[idx] = v;
    list_cnt++;
  endfunction

  function automatic void drop_at(input int unsigned idx);
    for (int unsigned i = idx; i + 1 < list_cnt; i++) begin
      list_mem[i] = list_mem[i+1];
    end
    list_cnt--;
  endfunction

  function automatic list_status_t apply_list_op(input logic [2:0] f,
                                                 input logic signed [VAL_W-1:0] v,
                                                 input logic [POS_W-1:0] p);
    list_status_t s;
    int unsigned  lim;
    lim = (cap_now < LIST_DEPTH) ? cap_now : LIST_DEPTH;
    s.ok = 1'b0;
    case (f)
      FN_APPEND: begin
        if (list_cnt < lim) begin
          store_at(list_cnt, v);
          s.ok = 1'b1;
        end
      end
      FN_PREPEND: begin
        if (list_cnt < lim) begin
          store_at(0, v);
          s.ok = 1'b1;
        end
      end
      FN_INSERT_AT: begin
        if (list_cnt < lim && p >= 1 && p <= list_cnt + 1) begin
          store_at(p - 1, v);
          s.ok = 1'b1;
        end
      end
      FN_REMOVE_LAST: begin
        if (list_cnt > 0) begin
          list_cnt--;
          s.ok = 1'b1;
        end
      end
      FN_REMOVE_FIRST: begin
        if (list_cnt > 0) begin
          drop_at(0);
          s.ok = 1'b1;
        end
      end
      FN_REMOVE_AT: begin
        if (list_cnt > 0 && p >= 1 && p <= list_cnt) begin
          drop_at(p - 1);
          s.ok = 1'b1;
        end
      end
      FN_SEARCH: begin
        for (int unsigned i = 0; i < list_cnt; i++) begin
          if (list_mem[i] == v) s.ok = 1'b1;
        end
      end
      default: ;
    endcase
    s.cnt = list_cnt[CNT_W-1:0];
    s.full = (list_cnt >= lim);
    s.empty = (list_cnt == 0);
    return s;
  endfunction

  task automatic note_mismatch(input string what, input list_status_t want,
                               input list_status_t got);
    bad_status_cnt++;
    if (bad_status_cnt <= 10) begin
      $display("%0t %s: expected ok=%0d cnt=%0d full=%0d empty=%0d, got ok=%0d cnt=%0d full=%0d empty=%0d",
               $time, what, want.ok, want.cnt, want.full, want.empty,
               got.ok, got.cnt, got.full, got.empty);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen_status = '{out_ok, out_entry_count, out_is_full, out_is_empty};
      if (pending_status.size() == 0) begin
        note_mismatch("unexpected item", '0, seen_status);
      end else begin
        owed_status = pending_status.pop_front();
        if (seen_status.ok !== owed_status.ok || seen_status.cnt !== owed_status.cnt ||
            seen_status.full !== owed_status.full || seen_status.empty !== owed_status.empty) begin
          note_mismatch("wrong status", owed_status, seen_status);
        end
      end
    end
    if (rst_n && in_valid === 1'b1 && in_stall === 1'b0) begin
      owed_status = apply_list_op(in_func, in_value, in_position);
      if (row_typed) owed_status = row_want;
      pending_status.push_back(owed_status);
    end
    if (cfg_we) cap_now = 32'(cfg_wdata);
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_op(input logic [2:0] f, input logic signed [VAL_W-1:0] v,
                         input logic [POS_W-1:0] p, input logic typed,
                         input list_status_t want);
    in_valid <= 1'b1;
    in_func <= f;
    in_value <= v;
    in_position <= p;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_for_drain();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned             ph_cap [N_PHASES];
    int                      ph_mode [N_PHASES];
    int unsigned             ins_pct [3];
    int unsigned             rem_pct [3];
    int unsigned             roll;
    int unsigned             sel;
    int unsigned             span;
    logic [2:0]              f;
    logic signed [VAL_W-1:0] v;
    logic [POS_W-1:0]        p;

    script[0]  = '{ROW_OP, FN_REMOVE_LAST, 32'sd0, 7'd0, CHK_TYPED, st(0, 0, 0, 1)};
    script[1]  = '{ROW_OP, FN_REMOVE_FIRST, 32'sd0, 7'd0, CHK_TYPED, st(0, 0, 0, 1)};
    script[2]  = '{ROW_OP, FN_REMOVE_AT, 32'sd0, 7'd1, CHK_TYPED, st(0, 0, 0, 1)};
    script[3]  = '{ROW_OP, FN_SEARCH, 32'sd0, 7'd0, CHK_TYPED, st(0, 0, 0, 1)};
    script[4]  = '{ROW_OP, FN_UNUSED, -32'sd1, 7'd127, CHK_TYPED, st(0, 0, 0, 1)};
    script[5]  = '{ROW_OP, FN_INSERT_AT, 32'sd9, 7'd0, CHK_TYPED, st(0, 0, 0, 1)};
    script[6]  = '{ROW_OP, FN_INSERT_AT, 32'sd9, 7'd2, CHK_TYPED, st(0, 0, 0, 1)};
    script[7]  = '{ROW_OP, FN_APPEND, 32'h7fffffff, 7'd0, CHK_TYPED, st(1, 1, 0, 0)};
    script[8]  = '{ROW_OP, FN_PREPEND, 32'h80000000, 7'd0, CHK_TYPED, st(1, 2, 0, 0)};
    script[9]  = '{ROW_OP, FN_INSERT_AT, -32'sd1, 7'd2, CHK_TYPED, st(1, 3, 0, 0)};
    script[10] = '{ROW_OP, FN_INSERT_AT, 32'sd0, 7'd4, CHK_TYPED, st(1, 4, 0, 0)};
    script[11] = '{ROW_OP, FN_SEARCH, 32'h80000000, 7'd0, CHK_MODEL, '0};
    script[12] = '{ROW_OP, FN_REMOVE_AT, 32'sd0, 7'd5, CHK_TYPED, st(0, 4, 0, 0)};
    script[13] = '{ROW_OP, FN_REMOVE_AT, 32'sd0, 7'd127, CHK_TYPED, st(0, 4, 0, 0)};
    script[14] = '{ROW_OP, FN_INSERT_AT, 32'sd3, 7'd127, CHK_TYPED, st(0, 4, 0, 0)};
    script[15] = '{ROW_OP, FN_REMOVE_AT, 32'sd0, 7'd2, CHK_TYPED, st(1, 3, 0, 0)};
    script[16] = '{ROW_OP, FN_SEARCH, -32'sd1, 7'd0, CHK_MODEL, '0};
    script[17] = '{ROW_OP, FN_REMOVE_FIRST, 32'sd0, 7'd0, CHK_TYPED, st(1, 2, 0, 0)};
    script[18] = '{ROW_CFG, 3'd0, 32'sd2, 7'd0, CHK_MODEL, '0};
    script[19] = '{ROW_OP, FN_APPEND, 32'sd5, 7'd0, CHK_TYPED, st(0, 2, 1, 0)};
    script[20] = '{ROW_OP, FN_PREPEND, 32'sd6, 7'd0, CHK_TYPED, st(0, 2, 1, 0)};
    script[21] = '{ROW_OP, FN_REMOVE_LAST, 32'sd0, 7'd0, CHK_TYPED, st(1, 1, 0, 0)};
    script[22] = '{ROW_CFG, 3'd0, 32'sd0, 7'd0, CHK_MODEL, '0};
    script[23] = '{ROW_OP, FN_APPEND, 32'sd7, 7'd0, CHK_TYPED, st(0, 1, 1, 0)};
    script[24] = '{ROW_OP, FN_REMOVE_AT, 32'sd0, 7'd1, CHK_TYPED, st(1, 0, 1, 1)};
    script[25] = '{ROW_OP, FN_UNUSED, 32'sd0, 7'd0, CHK_TYPED, st(0, 0, 1, 1)};
    script[26] = '{ROW_CFG, 3'd0, 32'sd127, 7'd0, CHK_MODEL, '0};
    script[27] = '{ROW_OP, FN_INSERT_AT, 32'h5a5a5a5a, 7'd1, CHK_TYPED, st(1, 1, 0, 0)};

    ph_cap = '{64, 10, 127, 0, 64, 1, 3, 0, 2, 64, 0, 64};
    ph_cap[7] = $urandom_range(1, 64);
    ph_cap[10] = $urandom_range(4, 40);
    ph_mode = '{MODE_FILL, MODE_MIX, MODE_FILL, MODE_MIX, MODE_DRAIN, MODE_MIX,
                MODE_MIX, MODE_FILL, MODE_MIX, MODE_DRAIN, MODE_MIX, MODE_MIX};
    ins_pct = '{85, 15, 42};
    rem_pct = '{7, 75, 42};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (script[i].kind == ROW_CFG) begin
        write_capacity(script[i].v[CAP_W-1:0]);
      end else begin
        send_op(script[i].f, script[i].v, script[i].p, script[i].typed, script[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      idle_on = (ph % 3 != 2) && (ph != N_PHASES - 1);
      write_capacity(ph_cap[ph][CAP_W-1:0]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_pct[ph_mode[ph]]) begin
          case ($urandom_range(0, 2))
            0: f = FN_APPEND;
            1: f = FN_PREPEND;
            default: f = FN_INSERT_AT;
          endcase
        end else if (roll < ins_pct[ph_mode[ph]] + rem_pct[ph_mode[ph]]) begin
          case ($urandom_range(0, 2))
            0: f = FN_REMOVE_LAST;
            1: f = FN_REMOVE_FIRST;
            default: f = FN_REMOVE_AT;
          endcase
        end else if (roll % 8 == 0) begin
          f = FN_UNUSED;
        end else begin
          f = FN_SEARCH;
        end

        sel = $urandom_range(0, 9);
        if (sel < 4) begin
          v = $signed($urandom_range(0, 15)) - 8;
        end else if (sel < 6 && list_cnt != 0) begin
          v = list_mem[$urandom_range(0, list_cnt - 1)];
        end else if (sel == 6) begin
          case ($urandom_range(0, 3))
            0: v = 32'h80000000;
            1: v = 32'h7fffffff;
            2: v = -32'sd1;
            default: v = 32'sd0;
          endcase
        end else begin
          v = $urandom();
        end

        span = (f == FN_INSERT_AT) ? list_cnt + 1 : list_cnt;
        sel = $urandom_range(0, 9);
        if (sel < 7 && span != 0) begin
          p = POS_W'($urandom_range(1, span));
        end else if (sel == 7) begin
          p = '0;
        end else if (sel == 8) begin
          p = POS_W'(span + 1);
        end else begin
          p = POS_W'($urandom_range(0, 127));
        end

        send_op(f, v, p, CHK_MODEL, '0);
      end
    end

    wait_for_drain();
    repeat (4) @(posedge clk);
    if (bad_status_cnt == 0 && pending_status.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
